@@ rtl/ugp_pkg.sv @@
// ugp_pkg: shared types, codes and constants for the hid gamepad endpoint
// holds the report descriptor rom as a constant table
// no dependencies
package ugp_pkg;

    // pad geometry
    localparam int NUM_AXES      = 4;
    localparam int NUM_BUTTONS   = 12;
    localparam logic [3:0] HAT_NULL_CODE = 4'd8;
    localparam int MAX_PACKET    = 8;

    // reply sizing
    localparam int REPORT_LEN    = 6;
    localparam int DESC_LEN      = 66;
    localparam int PKT_BYTES     = (MAX_PACKET < 8) ? MAX_PACKET : 8;
    localparam int IDX_W         = $clog2(PKT_BYTES);

    localparam logic [7:0] AXIS_CENTER      = 8'h80;
    localparam logic [7:0] DESC_TYPE_REPORT = 8'h22;
    localparam logic [3:0] ENDPOINT_PAD     = 4'd1;

    // item tdata width, padded to whole bytes
    localparam int IN_DATA_W     = 96;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 8;
    localparam int OUT_USER_W    = 4;

    typedef enum logic [2:0] {
        FN_SET_PAD     = 3'd0,
        FN_IN_TOKEN    = 3'd1,
        FN_GET_REPORT  = 3'd2,
        FN_GET_IDLE    = 3'd3,
        FN_SET_IDLE    = 3'd4,
        FN_REPORT_DESC = 3'd5,
        FN_BUS_RESET   = 3'd6,
        FN_OTHER       = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NAK   = 2'd1,
        ST_STALL = 2'd2
    } t_status;

    typedef logic [7:0] t_byte;

    // one decoded input word
    typedef struct packed {
        t_func                     func;
        logic [3:0][7:0]           axes;
        logic [7:0]                hat;
        logic [15:0]               buttons;
        logic [3:0]                endpoint;
        logic [7:0]                value_high;
        logic [15:0]               req_length;
        logic [6:0]                req_offset;
    } t_item;

    // reply plan for one item: up to PKT_BYTES output words
    typedef struct packed {
        t_status                   status;
        logic                      data_valid;
        logic                      wake;
        logic [IDX_W-1:0]          last_idx;
        logic [PKT_BYTES-1:0][7:0] bytes;
    } t_plan;

    localparam t_byte DESC_ROM [DESC_LEN] = '{
        8'h05, 8'h01, 8'h09, 8'h05, 8'ha1, 8'h01, 8'ha1, 8'h00,
        8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h32, 8'h09, 8'h35,
        8'h15, 8'h00, 8'h26, 8'hff, 8'h00, 8'h75, 8'h08, 8'h95,
        8'h04, 8'h81, 8'h02,
        8'h09, 8'h39, 8'h15, 8'h00, 8'h25, 8'h07, 8'h35, 8'h00,
        8'h46, 8'h3b, 8'h01, 8'h65, 8'h14, 8'h75, 8'h04, 8'h95,
        8'h01, 8'h81, 8'h42,
        8'h65, 8'h00, 8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h0c,
        8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h0c,
        8'h81, 8'h02, 8'hc0, 8'hc0
    };

    // descriptor byte lookup, zero past the end
    function automatic t_byte desc_byte(input logic [7:0] addr);
        t_byte b;
        b = 8'h00;
        if (int'(addr) < DESC_LEN) begin
            b = DESC_ROM[addr[6:0]];
        end
        return b;
    endfunction

endpackage

@@ rtl/ugp_reply.sv @@
// ugp_reply: pad state, idle rate and reply decode for one item
// depends on ugp_pkg
module ugp_reply (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ugp_pkg::t_item i_item,
    output ugp_pkg::t_plan o_plan
);
    import ugp_pkg::*;

    logic [NUM_AXES-1:0][7:0] r_axis, n_axis;
    logic [3:0]               r_hat, n_hat;
    logic [NUM_BUTTONS-1:0]   r_buttons, n_buttons;
    logic                     r_changed, n_changed;
    logic [7:0]               r_idle, n_idle;

    logic [3:0]               hat_clamped;
    logic [NUM_BUTTONS-1:0]   btn_masked;
    logic                     pad_diff;
    logic [11:0]              btn_report;
    logic [6:0]               desc_total;
    logic [6:0]               desc_remain;
    logic                     desc_empty;
    logic [IDX_W-1:0]         desc_last;
    t_plan                    plan;

    // pad compare, report and descriptor window
    always_comb begin
        hat_clamped = (i_item.hat > 8'(HAT_NULL_CODE)) ? HAT_NULL_CODE : i_item.hat[3:0];
        btn_masked  = i_item.buttons[NUM_BUTTONS-1:0];
        pad_diff    = (hat_clamped != r_hat) || (btn_masked != r_buttons);
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i_item.axes[i] != r_axis[i]) begin
                pad_diff = 1'b1;
            end
        end
        btn_report  = 12'(r_buttons);

        desc_total  = (i_item.req_length > 16'(DESC_LEN)) ? 7'(DESC_LEN)
                                                          : i_item.req_length[6:0];
        desc_empty  = i_item.req_offset >= desc_total;
        desc_remain = desc_total - i_item.req_offset;
        desc_last   = (desc_remain > 7'(PKT_BYTES)) ? IDX_W'(PKT_BYTES - 1)
                                                    : IDX_W'(desc_remain - 7'd1);
    end

    // reply plan and next state
    always_comb begin
        plan            = '0;
        plan.status     = ST_OK;
        n_axis          = r_axis;
        n_hat           = r_hat;
        n_buttons       = r_buttons;
        n_changed       = r_changed;
        n_idle          = r_idle;

        case (i_item.func)
            FN_SET_PAD: begin
                if (pad_diff) begin
                    n_axis    = i_item.axes[NUM_AXES-1:0];
                    n_hat     = hat_clamped;
                    n_buttons = btn_masked;
                    n_changed = 1'b1;
                    plan.wake = 1'b1;
                end
            end
            FN_IN_TOKEN, FN_GET_REPORT: begin
                if (i_item.func == FN_IN_TOKEN && i_item.endpoint != ENDPOINT_PAD) begin
                    plan.status = ST_STALL;
                end else if (i_item.func == FN_IN_TOKEN && !r_changed) begin
                    plan.status = ST_NAK;
                end else if (i_item.func == FN_GET_REPORT &&
                             i_item.req_length < 16'(REPORT_LEN)) begin
                    plan.status = ST_OK;
                end else begin
                    plan.data_valid = 1'b1;
                    plan.last_idx   = IDX_W'(REPORT_LEN - 1);
                    for (int i = 0; i < 4; i++) begin
                        plan.bytes[i] = (i < NUM_AXES) ? r_axis[i] : AXIS_CENTER;
                    end
                    plan.bytes[4] = {btn_report[3:0], r_hat};
                    plan.bytes[5] = btn_report[11:4];
                    n_changed     = 1'b0;
                end
            end
            FN_GET_IDLE: begin
                plan.data_valid = 1'b1;
                plan.bytes[0]   = r_idle;
            end
            FN_SET_IDLE: begin
                n_idle = i_item.value_high;
            end
            FN_REPORT_DESC: begin
                if (i_item.value_high != DESC_TYPE_REPORT) begin
                    plan.status = ST_STALL;
                end else if (!desc_empty) begin
                    plan.data_valid = 1'b1;
                    plan.last_idx   = desc_last;
                    for (int i = 0; i < PKT_BYTES; i++) begin
                        plan.bytes[i] = desc_byte({1'b0, i_item.req_offset} + 8'(i));
                    end
                end
            end
            FN_BUS_RESET: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    n_axis[i] = AXIS_CENTER;
                end
                n_hat     = HAT_NULL_CODE;
                n_buttons = '0;
                n_changed = 1'b1;
            end
            default: begin
                plan.status = ST_STALL;
            end
        endcase
    end

    assign o_plan = plan;

    // pad state, updated when the item is taken into the reply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_axis[i] <= AXIS_CENTER;
            end
            r_hat     <= HAT_NULL_CODE;
            r_buttons <= '0;
            r_changed <= 1'b1;
            r_idle    <= 8'h00;
        end else if (i_load) begin
            r_axis    <= n_axis;
            r_hat     <= n_hat;
            r_buttons <= n_buttons;
            r_changed <= n_changed;
            r_idle    <= n_idle;
        end
    end

endmodule

@@ rtl/usb_hid_gamepad_endpoint.sv @@
// usb_hid_gamepad_endpoint: hid gamepad function side, stream in and out
// the input register feeds the reply register when that is free; throughput: one input word
// per cycle when replies are single words and the output is not stalled; an item with
// n reply words (report 6, descriptor up to 8) holds the reply stage until all are taken
// reset: synchronous active-low, clears pipeline valids and restores pad state
// depends on ugp_pkg, ugp_reply
module usb_hid_gamepad_endpoint (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // axis_x, axis_y, axis_z, axis_rz, hat_in, buttons_in, endpoint_num,
    // value_high, req_length, req_offset, zero fill
    input  logic [ugp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [ugp_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // data_byte
    output logic [ugp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status, data_valid, wake_request
    output logic [ugp_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import ugp_pkg::*;

    logic             r_in_valid;
    t_item            r_in;
    logic             r_plan_valid;
    t_plan            r_plan;
    logic [IDX_W-1:0] r_idx;

    t_item            in_item;
    t_plan            plan;
    logic             in_take;
    logic             out_take;
    logic             plan_done;
    logic             plan_free;
    logic             load;

    // unpack the input word
    always_comb begin
        in_item.func       = t_func'(s_axis_tuser);
        in_item.axes[0]    = s_axis_tdata[7:0];
        in_item.axes[1]    = s_axis_tdata[15:8];
        in_item.axes[2]    = s_axis_tdata[23:16];
        in_item.axes[3]    = s_axis_tdata[31:24];
        in_item.hat        = s_axis_tdata[39:32];
        in_item.buttons    = s_axis_tdata[55:40];
        in_item.endpoint   = s_axis_tdata[59:56];
        in_item.value_high = s_axis_tdata[67:60];
        in_item.req_length = s_axis_tdata[83:68];
        in_item.req_offset = s_axis_tdata[90:84];
    end

    // handshake between input register and reply stage
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign plan_done     = out_take && (r_idx == r_plan.last_idx);
    assign plan_free     = !r_plan_valid || plan_done;
    assign load          = r_in_valid && plan_free;
    assign s_axis_tready = !r_in_valid || plan_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ugp_reply u_reply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (r_in),
        .o_plan  (plan)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !load);
        end
        if (in_take) begin
            r_in <= in_item;
        end
    end

    // reply register and word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan_valid <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_plan_valid <= load || (r_plan_valid && !plan_done);
            if (load) begin
                r_idx <= '0;
            end else if (out_take) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (load) begin
            r_plan <= plan;
        end
    end

    // output word
    assign m_axis_tvalid = r_plan_valid;
    assign m_axis_tdata  = r_plan.bytes[r_idx];
    assign m_axis_tlast  = (r_idx == r_plan.last_idx);
    assign m_axis_tuser  = {r_plan.wake, r_plan.data_valid, r_plan.status};

endmodule

@@ rtl/ugp_checker.sv @@
// ugp_checker: port-level assertions for the hid gamepad endpoint
// depends on ugp_pkg; bound to usb_hid_gamepad_endpoint
module ugp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ugp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ugp_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ugp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ugp_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast
);
    import ugp_pkg::*;

    // no output word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // nak and stall are single empty words
    a_nak_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ST_NAK || m_axis_tuser[1:0] == ST_STALL) |->
            m_axis_tlast && !m_axis_tuser[2] && m_axis_tdata == 8'h00 && !m_axis_tuser[3])
        else $error("nak or stall word carries data");

    // wake only on a single set-pad word without data
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tlast && !m_axis_tuser[2] && m_axis_tuser[1:0] == ST_OK)
        else $error("wake request on a data word");

    // a multi-word reply keeps data_valid until its last word
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser[2] && $past(m_axis_tuser[2]))
        else $error("reply burst broken");

endmodule

bind usb_hid_gamepad_endpoint ugp_checker u_ugp_checker (.*);
